[design/sbpr_pkg.sv]
// Shared types, register indexes and a helper function of the byte pattern replacer.
package sbpr_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int REPLACE_MAX_DEF = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD_CASE          = 3'd4;

  typedef struct packed {
    logic accept;
    logic eval;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic eval_empty;
    logic emit_last;
  } sts_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    logic [7:0] r;
    r = b;
    if (en && (b inside {[8'h41 : 8'h5A]})) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

[design/stream_byte_pattern_replacer.sv]
// Top level of the streaming byte pattern replacer.
//
//   Channel  Handshake          Payload
//   in_      in_valid/in_stall  in_data_byte, in_stream_last
//   out_     out_valid/out_stall out_byte, out_run_end
//   cfg_     cfg_valid/cfg_ready cfg_index, cfg_data
//
// An input byte is loaded, then evaluated, then its result bytes are emitted in order;
// a byte with no result returns to accepting input right after its evaluation.
// The evaluation compares every shift of the held window with the pattern in parallel.
// in_stall stays high from a transfer until its last result has been taken.
// out_stall holds the current result byte; reset is synchronous and empties the window.
module stream_byte_pattern_replacer #(
  parameter int PATTERN_MAX = sbpr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = sbpr_pkg::REPLACE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_stream_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            out_run_end,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sbpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbpr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sbpr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sbpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbpr_datapath #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_data_byte   (in_data_byte),
    .in_stream_last (in_stream_last),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end)
  );

endmodule

[design/sbpr_ctrl.sv]
// Controller state machine that sequences accept, evaluation and result emission.
module sbpr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  sbpr_pkg::sts_t sts,
  output sbpr_pkg::cmd_t cmd
);
  import sbpr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.accept  = 1'b0;
    cmd.eval    = 1'b0;
    cmd.advance = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.eval_empty ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall) begin
          cmd.advance = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_EMIT);

endmodule

[design/sbpr_datapath.sv]
// Datapath with configuration registers, match window, prefix compare and output buffer.
module sbpr_datapath #(
  parameter int PATTERN_MAX = sbpr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = sbpr_pkg::REPLACE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sbpr_pkg::cmd_t                  cmd,
  output sbpr_pkg::sts_t                  sts,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_stream_last,
  input  logic                            cfg_we,
  input  logic [sbpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbpr_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [7:0]                      out_byte,
  output logic                            out_run_end
);
  import sbpr_pkg::*;

  localparam int BUF_MAX = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
  localparam int CNT_W   = $clog2(PATTERN_MAX + 1);
  localparam int ECNT_W  = $clog2(BUF_MAX + 1);
  localparam int WIN_W   = PATTERN_MAX * 8;
  localparam int BUF_W   = BUF_MAX * 8;
  localparam int REP_W   = REPLACE_MAX * 8;
  localparam int WIDX_W  = $clog2(WIN_W);

  logic [63:0] pattern_r;
  logic [3:0]  plen_raw_r;
  logic [63:0] replace_r;
  logic [3:0]  rlen_raw_r;
  logic        fold_r;

  logic [WIN_W-1:0]  win_r;
  logic [CNT_W-1:0]  count_r;
  logic              last_r;
  logic [BUF_W-1:0]  buf_r;
  logic [ECNT_W-1:0] ecnt_r;
  logic [ECNT_W-1:0] k_r;

  logic [CNT_W-1:0]       plen;
  logic [ECNT_W-1:0]      rlen;
  logic [PATTERN_MAX-1:0] pre_ok;
  logic [CNT_W-1:0]       shift_sel;
  logic                   full_match;
  logic [63:0]            ext_win;
  logic [63:0]            ext_rep;
  logic [BUF_W-1:0]       buf_nxt;
  logic [ECNT_W-1:0]      ecnt_nxt;
  logic [WIN_W-1:0]       win_shift;
  logic [BUF_W-1:0]       buf_shift;
  logic [WIDX_W-1:0]      wr_base;

  always_comb begin
    if (plen_raw_r == 4'd0) begin
      plen = CNT_W'(1);
    end else if (32'(plen_raw_r) > PATTERN_MAX) begin
      plen = CNT_W'(PATTERN_MAX);
    end else begin
      plen = CNT_W'(plen_raw_r);
    end
    if (32'(rlen_raw_r) > REPLACE_MAX) begin
      rlen = ECNT_W'(REPLACE_MAX);
    end else begin
      rlen = ECNT_W'(rlen_raw_r);
    end
  end

  always_comb begin
    for (int s = 0; s < PATTERN_MAX; s++) begin
      pre_ok[s] = 1'b1;
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (s + j < PATTERN_MAX) begin
          if (CNT_W'(s + j) < count_r) begin
            if (fold_byte(win_r[(s+j)*8 +: 8], fold_r) !=
                fold_byte(pattern_r[j*8 +: 8], fold_r)) begin
              pre_ok[s] = 1'b0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    shift_sel = count_r;
    for (int s = PATTERN_MAX - 1; s >= 0; s--) begin
      if (CNT_W'(s) < count_r && pre_ok[s]) begin
        shift_sel = CNT_W'(s);
      end
    end
  end

  assign full_match = (count_r == plen) && pre_ok[0];
  assign win_shift  = win_r >> {shift_sel, 3'b000};
  assign wr_base    = WIDX_W'({count_r, 3'b000});

  always_comb begin
    ext_win = '0;
    ext_win[WIN_W-1:0] = win_r;
    ext_rep = '0;
    ext_rep[REP_W-1:0] = replace_r[REP_W-1:0];
    if (full_match) begin
      buf_nxt  = ext_rep[BUF_W-1:0];
      ecnt_nxt = rlen;
    end else begin
      buf_nxt  = ext_win[BUF_W-1:0];
      ecnt_nxt = last_r ? ECNT_W'(count_r) : ECNT_W'(shift_sel);
    end
  end

  assign sts.eval_empty = (ecnt_nxt == '0);
  assign sts.emit_last  = ((k_r + 1'b1) == ecnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r  <= '0;
      plen_raw_r <= 4'd1;
      replace_r  <= '0;
      rlen_raw_r <= 4'd0;
      fold_r     <= 1'b0;
      count_r    <= '0;
      last_r     <= 1'b0;
      ecnt_r     <= '0;
      k_r        <= '0;
    end else begin
      if (cmd.accept) begin
        count_r <= count_r + 1'b1;
        last_r  <= in_stream_last;
      end
      if (cmd.eval) begin
        ecnt_r <= ecnt_nxt;
        k_r    <= '0;
        if (full_match || last_r) begin
          count_r <= '0;
        end else begin
          count_r <= count_r - shift_sel;
        end
      end
      if (cmd.advance) begin
        k_r <= k_r + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_BYTES: begin
            pattern_r <= cfg_data;
          end
          REG_PATTERN_LENGTH: begin
            plen_raw_r <= cfg_data[3:0];
            count_r    <= '0;
          end
          REG_REPLACEMENT_BYTES: begin
            replace_r <= cfg_data;
          end
          REG_REPLACEMENT_LENGTH: begin
            rlen_raw_r <= cfg_data[3:0];
          end
          REG_FOLD_CASE: begin
            fold_r <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      win_r[wr_base +: 8] <= in_data_byte;
    end
    if (cmd.eval) begin
      buf_r <= buf_nxt;
      win_r <= win_shift;
    end
  end

  assign buf_shift   = buf_r >> {k_r, 3'b000};
  assign out_byte    = buf_shift[7:0];
  assign out_run_end = sts.emit_last;

endmodule
